// ===== design/ssc_pkg.sv =====
package ssc_pkg;

	localparam int ENTRIES_DEF  = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int CAP_BITS     = 7;
	localparam int CAP_RESET    = 64;
	localparam int CNT_BITS     = 32;
	localparam int STAMP_BITS   = 64;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic {
		OP_ENCOUNTER = 1'b0,
		OP_QUERY     = 1'b1
	} op_t;

	typedef struct packed {
		logic        op;
		logic [31:0] item_key;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] item_count;
		logic [31:0] item_error;
		logic        evicted;
		logic [31:0] evicted_key;
	} out_item_t;

	typedef struct packed {
		logic                  vld;
		logic                  hit;
		logic                  has_best;
		logic [CNT_BITS-1:0]   hit_count;
		logic [CNT_BITS-1:0]   hit_err;
		logic [CNT_BITS-1:0]   best_count;
		logic [STAMP_BITS-1:0] best_stamp;
	} tok_t;

	typedef struct packed {
		logic                  en;
		logic [CNT_BITS-1:0]   count;
		logic [CNT_BITS-1:0]   err;
		logic [STAMP_BITS-1:0] stamp;
	} wr_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== design/ssc_cell.sv =====
module ssc_cell import ssc_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int IDX      = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(ENTRIES+1)-1:0] occ,
	input  logic [KEY_BITS-1:0]          key,
	input  tok_t                         tin,
	input  logic [$clog2(ENTRIES)-1:0]   tin_hit_idx,
	input  logic [$clog2(ENTRIES)-1:0]   tin_best_idx,
	input  logic [KEY_BITS-1:0]          tin_best_key,
	output tok_t                         tout,
	output logic [$clog2(ENTRIES)-1:0]   tout_hit_idx,
	output logic [$clog2(ENTRIES)-1:0]   tout_best_idx,
	output logic [KEY_BITS-1:0]          tout_best_key,
	input  wr_t                          wr,
	input  logic [$clog2(ENTRIES)-1:0]   wr_idx,
	input  logic [KEY_BITS-1:0]          wr_key
);
	localparam int IW = $clog2(ENTRIES);
	localparam int OW = $clog2(ENTRIES+1);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [OW-1:0] MY_OCC = OW'(IDX);

	logic [KEY_BITS-1:0]   key_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   err_q;
	logic [STAMP_BITS-1:0] stamp_q;

	logic                  occd;
	tok_t                  t;
	logic [IW-1:0]         t_hit_idx;
	logic [IW-1:0]         t_best_idx;
	logic [KEY_BITS-1:0]   t_best_key;

	assign occd = MY_OCC < occ;

	always_comb begin
		t          = tin;
		t_hit_idx  = tin_hit_idx;
		t_best_idx = tin_best_idx;
		t_best_key = tin_best_key;
		if (tin.vld && occd) begin
			if (!tin.hit && key_q == key) begin
				t.hit       = 1'b1;
				t.hit_count = count_q;
				t.hit_err   = err_q;
				t_hit_idx   = MY_IDX;
			end
			if (!tin.has_best || count_q < tin.best_count ||
			    (count_q == tin.best_count && stamp_q < tin.best_stamp)) begin
				t.has_best   = 1'b1;
				t.best_count = count_q;
				t.best_stamp = stamp_q;
				t_best_idx   = MY_IDX;
				t_best_key   = key_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout          <= '0;
			tout_hit_idx  <= '0;
			tout_best_idx <= '0;
			tout_best_key <= '0;
		end else begin
			tout          <= t;
			tout_hit_idx  <= t_hit_idx;
			tout_best_idx <= t_best_idx;
			tout_best_key <= t_best_key;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == MY_IDX) begin
			key_q   <= wr_key;
			count_q <= wr.count;
			err_q   <= wr.err;
			stamp_q <= wr.stamp;
		end
	end

endmodule

// ===== design/space_saving_topk_counter.sv =====
// items are handled one at a time: a new item is accepted only in the idle state,
// once the previous result has been emitted; the match and minimum token walks
// the chain of ENTRIES cells one cell per cycle, then the chosen cell is written
// a new item is taken while the previous result still waits on the output register
// reset: occupancy and sequence clear, capacity returns to 64; table contents undefined
module space_saving_topk_counter import ssc_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_item,
	input  logic                cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata
);
	localparam int IW = $clog2(ENTRIES);
	localparam int OW = $clog2(ENTRIES+1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_HOLD
	} state_t;

	state_t                state_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [OW-1:0]         occ_q;
	logic [STAMP_BITS-1:0] seq_q;
	logic                  start_q;
	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	tok_t                  res_q;
	logic [IW-1:0]         res_hit_idx_q;
	logic [IW-1:0]         res_best_idx_q;
	logic [KEY_BITS-1:0]   res_best_key_q;

	tok_t                  tok      [ENTRIES+1];
	logic [IW-1:0]         hit_idx  [ENTRIES+1];
	logic [IW-1:0]         best_idx [ENTRIES+1];
	logic [KEY_BITS-1:0]   best_key [ENTRIES+1];

	wr_t                   wr;
	logic [IW-1:0]         wr_idx;
	logic [KEY_BITS-1:0]   wr_key;
	logic [OW-1:0]         eff_cap;
	logic                  emit;
	logic                  room;
	out_item_t             res_item;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		tok[0]            = '0;
		tok[0].vld        = start_q;
		hit_idx[0]        = '0;
		best_idx[0]       = '0;
		best_key[0]       = '0;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ssc_cell #(
			.ENTRIES (ENTRIES),
			.KEY_BITS(KEY_BITS),
			.IDX     (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.occ          (occ_q),
			.key          (key_q),
			.tin          (tok[i]),
			.tin_hit_idx  (hit_idx[i]),
			.tin_best_idx (best_idx[i]),
			.tin_best_key (best_key[i]),
			.tout         (tok[i+1]),
			.tout_hit_idx (hit_idx[i+1]),
			.tout_best_idx(best_idx[i+1]),
			.tout_best_key(best_key[i+1]),
			.wr           (wr),
			.wr_idx       (wr_idx),
			.wr_key       (wr_key)
		);
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = OW'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			eff_cap = OW'(ENTRIES);
		end else begin
			eff_cap = OW'(cap_q);
		end
	end

	assign emit = state_q == ST_HOLD && (!out_valid_q || out_ready);
	assign room = occ_q < eff_cap;

	always_comb begin
		wr          = '0;
		wr.stamp    = seq_q;
		wr_idx      = res_hit_idx_q;
		wr_key      = key_q;
		res_item    = '0;
		if (op_q == OP_QUERY) begin
			if (res_q.hit) begin
				res_item.found      = 1'b1;
				res_item.item_count = res_q.hit_count;
				res_item.item_error = res_q.hit_err;
			end
		end else begin
			wr.en = emit;
			if (res_q.hit) begin
				wr.count = sat_inc(res_q.hit_count);
				wr.err   = res_q.hit_err;
			end else if (room) begin
				wr_idx   = occ_q[IW-1:0];
				wr.count = CNT_BITS'(1);
				wr.err   = '0;
			end else begin
				wr_idx               = res_best_idx_q;
				wr.count             = sat_inc(res_q.best_count);
				wr.err               = res_q.best_count;
				res_item.evicted     = 1'b1;
				res_item.evicted_key = 32'(res_best_key_q);
			end
			res_item.found      = 1'b1;
			res_item.item_count = wr.count;
			res_item.item_error = wr.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_BITS'(CAP_RESET);
			occ_q       <= '0;
			seq_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						start_q <= 1'b1;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (tok[ENTRIES].vld) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (op_q == OP_ENCOUNTER) begin
							seq_q <= seq_q + 1'b1;
							if (!res_q.hit && room) begin
								occ_q <= occ_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_item.op;
			key_q <= KEY_BITS'(in_item.item_key);
		end
		if (state_q == ST_SWEEP && tok[ENTRIES].vld) begin
			res_q          <= tok[ENTRIES];
			res_hit_idx_q  <= hit_idx[ENTRIES];
			res_best_idx_q <= best_idx[ENTRIES];
			res_best_key_q <= best_key[ENTRIES];
		end
		if (emit) begin
			out_q <= res_item;
		end
	end

	a_tail_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tok[ENTRIES].vld |-> state_q == ST_SWEEP)
		else $error("token left the chain outside the sweep");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= ENTRIES)
		else $error("occupancy beyond table size");

	a_write_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == ST_HOLD && op_q == OP_ENCOUNTER)
		else $error("table write outside result stage");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> start_q && state_q == ST_SWEEP)
		else $error("accepted item did not start a sweep");

endmodule
